>>> hdl/acrms_pkg.sv
// shared types and constants for the ac rms voltage meter
`default_nettype none

package acrms_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int VOLT_W     = 16;
  localparam int GAIN_W     = 20;
  localparam int OFFSET_W   = 16;
  localparam int OFF_SUM_W  = 19;
  localparam int OFF_CNT_W  = 7;
  localparam int SQ_SUM_W   = 48;
  localparam int WIN_CNT_W  = 17;
  localparam int ROOT_W     = 24;
  localparam int REM_W      = 27;
  localparam int PROD_W     = 36;
  localparam int STEP_W     = 6;
  localparam int DIV_STEPS  = 48;
  localparam int SQRT_STEPS = 24;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;

  localparam logic [OFFSET_W-1:0] DC_OFFSET_RESET = 16'h8000;
  localparam logic [GAIN_W-1:0]   GAIN_RESET      = 20'd53;

  typedef enum logic [2:0] {
    REG_GAIN_CH0      = 3'd0,
    REG_GAIN_CH1      = 3'd1,
    REG_ZERO_THR      = 3'd2,
    REG_MOTOR_THR_CH0 = 3'd3,
    REG_MOTOR_THR_CH1 = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                channel;
    logic [SAMPLE_W-1:0] sample;
    logic                window_end;
  } in_beat_t;

  typedef struct packed {
    logic              result_channel;
    logic [VOLT_W-1:0] rms_voltage;
    logic              motor_running;
  } out_beat_t;

endpackage

`default_nettype wire

>>> hdl/ac_rms_voltage_meter_top.sv
// ac rms voltage meter: offset calibration, square accumulation, divide, root, scaling
// ordinary sample: next beat can be taken once the square and accumulate steps are done
// calibration sample: summed; the one that ends calibration adds a step (reciprocal multiply)
// window end: result valid after square, 48 divide and 24 root steps
//   on the shared 27-bit subtractor, multiply and round; next beat taken once
//   the result is loaded, later while an earlier result waits under out_stall
// synchronous active-low reset: offsets to mid-scale, calibration restarts, gains 53
`default_nettype none

module ac_rms_voltage_meter_top
  import acrms_pkg::*;
#(
  parameter int NUM_CHANNELS  = 2,
  parameter int CALIB_SAMPLES = 100,
  parameter int MAX_WINDOW    = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // sample channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_beat_t           in_data,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_beat_t               out_data,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int CALIB_HALF = CALIB_SAMPLES / 2;

  // offset average by reciprocal multiplication, exact for dividends below 2^23
  localparam int CAL_X_W     = OFF_SUM_W + 4;
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 32;
  localparam logic [RECIP_W-1:0] CALIB_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) / CALIB_SAMPLES) + 1);

  // sequencer, one-hot
  typedef enum logic [8:0] {
    S_IDLE   = 9'b0_0000_0001,
    S_CALIB  = 9'b0_0000_0010,
    S_DIV    = 9'b0_0000_0100,
    S_SQDIFF = 9'b0_0000_1000,
    S_ACC    = 9'b0_0001_0000,
    S_SQRT   = 9'b0_0010_0000,
    S_SCALE  = 9'b0_0100_0000,
    S_OUT    = 9'b0_1000_0000,
    S_OFFSET = 9'b1_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [GAIN_W-1:0] gain_r      [2];
  logic [GAIN_W-1:0] gain_nxt    [2];
  logic [VOLT_W-1:0] zero_thr_r, zero_thr_nxt;
  logic [VOLT_W-1:0] motor_thr_r   [2];
  logic [VOLT_W-1:0] motor_thr_nxt [2];

  // per-channel measurement state
  logic [OFFSET_W-1:0]  dc_offset_r     [2];
  logic [OFFSET_W-1:0]  dc_offset_nxt   [2];
  logic                 offset_ready_r  [2];
  logic                 offset_ready_nxt[2];
  logic [OFF_SUM_W-1:0] offset_sum_r    [2];
  logic [OFF_SUM_W-1:0] offset_sum_nxt  [2];
  logic [OFF_CNT_W-1:0] offset_count_r  [2];
  logic [OFF_CNT_W-1:0] offset_count_nxt[2];
  logic [SQ_SUM_W-1:0]  square_sum_r    [2];
  logic [SQ_SUM_W-1:0]  square_sum_nxt  [2];
  logic [WIN_CNT_W-1:0] window_count_r  [2];
  logic [WIN_CNT_W-1:0] window_count_nxt[2];

  // captured beat
  logic                ch_r, ch_nxt;
  logic [SAMPLE_W-1:0] smp_r, smp_nxt;
  logic                wend_r, wend_nxt;

  // datapath of the shared unit
  logic [SQ_SUM_W-1:0]  q_r, q_nxt;          // dividend / quotient / radicand
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [ROOT_W-1:0]    root_r, root_nxt;
  logic [WIN_CNT_W-1:0] divisor_r, divisor_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_data_r, out_data_nxt;

  // shared subtract/compare unit
  logic [REM_W-1:0] sub_a, sub_b;
  logic [REM_W:0]   sub_diff;
  logic             sub_ge;

  // shared multiplier
  logic [VOLT_W-1:0] mul_a;
  logic [GAIN_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;

  // helpers
  logic                         ch_ok;
  logic                         cfg_wr;
  logic [OFFSET_W-1:0]          scaled;
  logic [OFFSET_W-1:0]          abs_d;
  logic [OFF_SUM_W-1:0]         cal_sum;
  logic [OFF_CNT_W-1:0]         cal_cnt;
  logic [CAL_X_W+RECIP_W-1:0]   offset_prod;
  logic                         win_room;
  logic [SQ_SUM_W-1:0]          acc_sum;
  logic [WIN_CNT_W-1:0]         acc_cnt;
  logic [VOLT_W-1:0]            rms_sat;
  logic [PROD_W:0]              rounded;
  logic [VOLT_W-1:0]            volts_sat;
  logic [VOLT_W-1:0]            volts_fl;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;

  assign ch_ok = (int'(in_data.channel) < NUM_CHANNELS);

  // one subtractor serves every divide and root step
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[REM_W];

  assign mul_p = mul_a * mul_b;

  // deviation of the sample from the channel offset, Q12.4
  assign scaled = {smp_r, 4'b0000};
  assign abs_d  = (scaled >= dc_offset_r[ch_r]) ? (scaled - dc_offset_r[ch_r])
                                                : (dc_offset_r[ch_r] - scaled);

  assign cal_sum = offset_sum_r[ch_r] + OFF_SUM_W'(smp_r);
  assign cal_cnt = offset_count_r[ch_r] + OFF_CNT_W'(1);

  // rounded offset sum times the reciprocal of the calibration count
  assign offset_prod = (CAL_X_W+RECIP_W)'(q_r[CAL_X_W-1:0]) *
                       (CAL_X_W+RECIP_W)'(CALIB_RECIP);

  // a full window drops further samples but still closes on the mark
  assign win_room = (window_count_r[ch_r] < WIN_CNT_W'(MAX_WINDOW));
  assign acc_sum  = win_room ? (square_sum_r[ch_r] + SQ_SUM_W'(prod_r)) : square_sum_r[ch_r];
  assign acc_cnt  = win_room ? (window_count_r[ch_r] + WIN_CNT_W'(1)) : window_count_r[ch_r];

  assign rms_sat = (|root_r[ROOT_W-1:VOLT_W]) ? {VOLT_W{1'b1}} : root_r[VOLT_W-1:0];

  // round half up to 1/16 V, saturate, then the noise floor
  assign rounded   = {1'b0, prod_r} + (PROD_W+1)'(32768);
  assign volts_sat = (|rounded[PROD_W:32]) ? {VOLT_W{1'b1}} : rounded[31:16];
  assign volts_fl  = (volts_sat < zero_thr_r) ? '0 : volts_sat;

  // register reads
  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_GAIN_CH0:      prdata = PDATA_W'(gain_r[0]);
      REG_GAIN_CH1:      prdata = PDATA_W'(gain_r[1]);
      REG_ZERO_THR:      prdata = PDATA_W'(zero_thr_r);
      REG_MOTOR_THR_CH0: prdata = PDATA_W'(motor_thr_r[0]);
      REG_MOTOR_THR_CH1: prdata = PDATA_W'(motor_thr_r[1]);
      default:           prdata = '0;
    endcase
  end

  // register writes
  always_comb begin
    gain_nxt      = gain_r;
    zero_thr_nxt  = zero_thr_r;
    motor_thr_nxt = motor_thr_r;
    if (cfg_wr) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_GAIN_CH0:      gain_nxt[0]      = pwdata[GAIN_W-1:0];
        REG_GAIN_CH1:      gain_nxt[1]      = pwdata[GAIN_W-1:0];
        REG_ZERO_THR:      zero_thr_nxt     = pwdata[VOLT_W-1:0];
        REG_MOTOR_THR_CH0: motor_thr_nxt[0] = pwdata[VOLT_W-1:0];
        REG_MOTOR_THR_CH1: motor_thr_nxt[1] = pwdata[VOLT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    dc_offset_nxt    = dc_offset_r;
    offset_ready_nxt = offset_ready_r;
    offset_sum_nxt   = offset_sum_r;
    offset_count_nxt = offset_count_r;
    square_sum_nxt   = square_sum_r;
    window_count_nxt = window_count_r;
    ch_nxt           = ch_r;
    smp_nxt          = smp_r;
    wend_nxt         = wend_r;
    q_nxt            = q_r;
    rem_nxt          = rem_r;
    root_nxt         = root_r;
    divisor_nxt      = divisor_r;
    step_nxt         = step_r;
    prod_nxt         = prod_r;
    out_data_nxt     = out_data_r;
    // a taken result beat frees the output register
    out_valid_nxt    = out_valid_r && out_stall;
    sub_a            = '0;
    sub_b            = '0;
    mul_a            = '0;
    mul_b            = '0;

    case (state_r)
      S_IDLE: begin
        // beats of an absent channel are dropped
        if (in_valid && ch_ok) begin
          ch_nxt    = in_data.channel;
          smp_nxt   = in_data.sample;
          wend_nxt  = in_data.window_end;
          state_nxt = offset_ready_r[in_data.channel] ? S_SQDIFF : S_CALIB;
        end
      end

      S_CALIB: begin
        // window marks are ignored until the offset is known
        offset_sum_nxt[ch_r]   = cal_sum;
        offset_count_nxt[ch_r] = cal_cnt;
        if (cal_cnt >= OFF_CNT_W'(CALIB_SAMPLES)) begin
          // dividend with the half-up rounding term
          q_nxt     = SQ_SUM_W'({cal_sum, 4'b0000}) + SQ_SUM_W'(CALIB_HALF);
          state_nxt = S_OFFSET;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_OFFSET: begin
        dc_offset_nxt[ch_r]    = offset_prod[RECIP_SHIFT +: OFFSET_W];
        offset_ready_nxt[ch_r] = 1'b1;
        state_nxt              = S_IDLE;
      end

      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        sub_a    = {9'b0, rem_r[WIN_CNT_W-1:0], q_r[SQ_SUM_W-1]};
        sub_b    = {10'b0, divisor_r};
        rem_nxt  = sub_ge ? sub_diff[REM_W-1:0] : sub_a;
        q_nxt    = {q_r[SQ_SUM_W-2:0], sub_ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = S_SQRT;
        end
      end

      S_SQDIFF: begin
        mul_a     = abs_d;
        mul_b     = GAIN_W'(abs_d);
        prod_nxt  = mul_p;
        state_nxt = S_ACC;
      end

      S_ACC: begin
        if (wend_r) begin
          square_sum_nxt[ch_r]   = '0;
          window_count_nxt[ch_r] = '0;
          if (acc_cnt == '0) begin
            // empty window reads as zero volts
            root_nxt  = '0;
            state_nxt = S_SCALE;
          end else begin
            q_nxt       = acc_sum;
            divisor_nxt = acc_cnt;
            rem_nxt     = '0;
            step_nxt    = '0;
            state_nxt   = S_DIV;
          end
        end else begin
          square_sum_nxt[ch_r]   = acc_sum;
          window_count_nxt[ch_r] = acc_cnt;
          state_nxt              = S_IDLE;
        end
      end

      S_SQRT: begin
        // digit-by-digit root, two radicand bits per cycle
        sub_a    = {rem_r[REM_W-3:0], q_r[SQ_SUM_W-1:SQ_SUM_W-2]};
        sub_b    = {1'b0, root_r, 2'b01};
        rem_nxt  = sub_ge ? sub_diff[REM_W-1:0] : sub_a;
        root_nxt = {root_r[ROOT_W-2:0], sub_ge};
        q_nxt    = {q_r[SQ_SUM_W-3:0], 2'b00};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
          state_nxt = S_SCALE;
        end
      end

      S_SCALE: begin
        mul_a     = rms_sat;
        mul_b     = gain_r[ch_r];
        prod_nxt  = mul_p;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        // hold here until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.result_channel = ch_r;
          out_data_nxt.rms_voltage    = volts_fl;
          out_data_nxt.motor_running  = (volts_fl > motor_thr_r[ch_r]);
          state_nxt                   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      gain_r[0]    <= GAIN_RESET;
      gain_r[1]    <= GAIN_RESET;
      zero_thr_r   <= '0;
      motor_thr_r[0] <= '0;
      motor_thr_r[1] <= '0;
      for (int i = 0; i < 2; i++) begin
        dc_offset_r[i]    <= DC_OFFSET_RESET;
        offset_ready_r[i] <= 1'b0;
        offset_sum_r[i]   <= '0;
        offset_count_r[i] <= '0;
        square_sum_r[i]   <= '0;
        window_count_r[i] <= '0;
      end
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      gain_r         <= gain_nxt;
      zero_thr_r     <= zero_thr_nxt;
      motor_thr_r    <= motor_thr_nxt;
      dc_offset_r    <= dc_offset_nxt;
      offset_ready_r <= offset_ready_nxt;
      offset_sum_r   <= offset_sum_nxt;
      offset_count_r <= offset_count_nxt;
      square_sum_r   <= square_sum_nxt;
      window_count_r <= window_count_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    ch_r         <= ch_nxt;
    smp_r        <= smp_nxt;
    wend_r       <= wend_nxt;
    q_r          <= q_nxt;
    rem_r        <= rem_nxt;
    root_r       <= root_nxt;
    divisor_r    <= divisor_nxt;
    step_r       <= step_nxt;
    prod_r       <= prod_nxt;
    out_data_r   <= out_data_nxt;
  end

  // once calibrated a channel stays calibrated
  a_ready_sticky0: assert property (@(posedge clk) disable iff (!rst_n)
    offset_ready_r[0] |=> offset_ready_r[0])
    else $error("channel 0 lost its offset");

  a_ready_sticky1: assert property (@(posedge clk) disable iff (!rst_n)
    offset_ready_r[1] |=> offset_ready_r[1])
    else $error("channel 1 lost its offset");

  // window counts never pass the window limit
  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (window_count_r[0] <= WIN_CNT_W'(MAX_WINDOW)) &&
    (window_count_r[1] <= WIN_CNT_W'(MAX_WINDOW)))
    else $error("window count over limit");

  // a new result only comes out of the output step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || !out_stall) && out_valid_nxt |-> state_r == S_OUT)
    else $error("result loaded outside output step");

  // no new beat is taken while a computation is running
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_SQRT) |=> (state_r != S_SQDIFF && state_r != S_CALIB))
    else $error("beat taken during divide or root");

endmodule

`default_nettype wire
